// ===== rtl/coverage_blend_pixel_writer_top_defines.svh =====
// Assertion macros shared by the pixel writer RTL.
// Plain text macros only; no dependencies.
`ifndef COVERAGE_BLEND_PIXEL_WRITER_TOP_DEFINES_SVH
`define COVERAGE_BLEND_PIXEL_WRITER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CBPW_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CBPW_ASSERT_NXT(name, clk_sig, rstn_sig, ante, cons, msg) \
    name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cbpw_pkg.sv =====
// Shared types and constants for the coverage blend pixel writer.
// No dependencies; cbpw_regs, cbpw_mul_unit and the top level use it by scoped names.
`default_nettype none

package cbpw_pkg;

    // Fixed widths of the shared multiplier, the accumulate path, t, the pixel coordinates and the register address
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 56;
    localparam int T_W     = 35;
    localparam int COORD_W = 13;
    localparam int PADDR_W = 6;

    // Operation codes
    localparam logic [1:0] FUNC_PAINT = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    // Register indexes (byte address 8*index)
    localparam logic [2:0] REG_SHADER_MODE  = 3'd0;
    localparam logic [2:0] REG_COLOR_START  = 3'd1;
    localparam logic [2:0] REG_COLOR_END    = 3'd2;
    localparam logic [2:0] REG_GRAD_START_X = 3'd3;
    localparam logic [2:0] REG_GRAD_SCALE   = 3'd4;

    // Coverage limits, Q1.16
    localparam logic [16:0] FULL_COV      = 17'h10000;
    localparam logic [24:0] LOW_COV_LIMIT = 25'h0010000;

    typedef struct packed {
        logic [1:0]  func;
        logic [6:0]  pixel_x;
        logic [6:0]  pixel_y;
        logic [16:0] coverage;
    } item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    typedef struct packed {
        logic               shader_mode;
        logic [63:0]        color_start;
        logic [63:0]        color_end;
        logic signed [15:0] grad_start_x;
        logic signed [17:0] grad_scale;
    } cfg_t;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;

    typedef struct packed {
        logic   en;
        mul_a_t a;
        mul_b_t b;
    } mul_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ_OUT,
        ST_T_MUL,
        ST_T_ACC,
        ST_G_MUL,
        ST_G_ACC,
        ST_F_MUL,
        ST_F_ACC,
        ST_B_MUL,
        ST_B_ACC,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/cbpw_regs.sv =====
// APB-style configuration register file for the pixel writer.
// Depends on cbpw_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module cbpw_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cbpw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                    pwdata,
    output logic      [63:0]                    prdata,
    output logic                                pready,
    output cbpw_pkg::cfg_t                      cfg
);

    cbpw_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[cbpw_pkg::PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Capture a write beat in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                cbpw_pkg::REG_SHADER_MODE:  cfg_reg.shader_mode  <= pwdata[0];
                cbpw_pkg::REG_COLOR_START:  cfg_reg.color_start  <= pwdata;
                cbpw_pkg::REG_COLOR_END:    cfg_reg.color_end    <= pwdata;
                cbpw_pkg::REG_GRAD_START_X: cfg_reg.grad_start_x <= pwdata[15:0];
                cbpw_pkg::REG_GRAD_SCALE:   cfg_reg.grad_scale   <= pwdata[17:0];
                default:                    ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            cbpw_pkg::REG_SHADER_MODE:  prdata = {63'd0, cfg_reg.shader_mode};
            cbpw_pkg::REG_COLOR_START:  prdata = cfg_reg.color_start;
            cbpw_pkg::REG_COLOR_END:    prdata = cfg_reg.color_end;
            cbpw_pkg::REG_GRAD_START_X: prdata = {48'd0, cfg_reg.grad_start_x};
            cbpw_pkg::REG_GRAD_SCALE:   prdata = {46'd0, cfg_reg.grad_scale};
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cbpw_frame_mem.sv =====
// Single-port frame store with registered read data.
// No package dependencies; sized by its parameters.
`default_nettype none

module cbpw_frame_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] frame_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // Write one pixel
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_mem[addr] <= wdata;
        end
    end

    // Read one pixel; hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= frame_mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cbpw_mul_unit.sv =====
// Shared signed multiplier with a registered product.
// Depends on cbpw_pkg for the operand and product types.
`default_nettype none

module cbpw_mul_unit (
    input  wire logic               clk,
    input  cbpw_pkg::mul_req_t      req,
    output cbpw_pkg::mul_p_t        product
);

    cbpw_pkg::mul_p_t product_reg;

    assign product = product_reg;

    // Multiply when the sequencer issues an operation; hold otherwise
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            product_reg <= cbpw_pkg::MUL_P_W'(req.a) * cbpw_pkg::MUL_P_W'(req.b);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/coverage_blend_pixel_writer_top.sv =====
// Coverage blend pixel writer: top level with the item sequencer.
// Depends on cbpw_pkg, cbpw_regs, cbpw_frame_mem, cbpw_mul_unit and the defines header.
// Input channel item_valid/item_ready carries one operation (paint, fill, read) on a
// pixel; output channel result_valid/result_ready carries the 8-bit RGBA of a read.
// Configuration goes through the APB-style port; the user must write it only while the
// block is idle, which the block itself does not enforce. One item at a time:
// item_ready is high only while the sequencer is idle. Items share the single
// multiplier: every multiply has an issue state and an accumulate state, one for the
// gradient position t, four for the gradient channels, one for the blend factor, four
// for the blend channels. A read result is loaded into an output register from
// ST_READ_OUT, after ST_DECODE; the next item is taken while it waits. A read that
// meets a full output register waits until the receiver takes the earlier result.
// Reset clears the configuration registers and the sequencer; the frame store is not
// cleared and a pixel reads as undefined until it is written.
`default_nettype none
`include "coverage_blend_pixel_writer_top_defines.svh"

module coverage_blend_pixel_writer_top #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128,
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cbpw_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                    pwdata,
    output logic      [63:0]                    prdata,
    output logic                                pready,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  cbpw_pkg::item_t                     item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output cbpw_pkg::result_t                   result
);

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB     = CHANNEL_BITS;
    localparam int PIX_W  = 4 * CB;
    localparam int SHIFT  = 16 + CB;
    localparam int AF_W   = 2 * cbpw_pkg::COORD_W;
    localparam int GQ_W   = cbpw_pkg::ACC_W - 16;
    localparam int BR_W   = cbpw_pkg::ACC_W - SHIFT;
    localparam logic [CB-1:0] CH_MAX = '1;
    localparam logic [CB:0]   CH_ONE = {1'b1, {CB{1'b0}}};
    localparam logic [cbpw_pkg::COORD_W-1:0] FW_C = cbpw_pkg::COORD_W'(FRAME_WIDTH);
    localparam logic [cbpw_pkg::COORD_W-1:0] FH_C = cbpw_pkg::COORD_W'(FRAME_HEIGHT);

    // Channel code to byte; all-ones stands for one
    function automatic logic [7:0] to_byte(input logic [CB-1:0] c);
        logic [CB+7:0] scaled;
        scaled = {c, 8'd0} - {8'd0, c};
        return (c == CH_MAX) ? 8'hFF : scaled[CB+7:CB];
    endfunction

    cbpw_pkg::cfg_t     cfg;
    cbpw_pkg::state_t   state_reg;
    cbpw_pkg::state_t   state_next;
    cbpw_pkg::item_t    item_reg;
    cbpw_pkg::result_t  result_reg;
    cbpw_pkg::mul_req_t mul_req;
    cbpw_pkg::mul_p_t   mul_product;

    logic                   result_valid_reg;
    logic [1:0]             ch_reg;
    logic                   inside_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic signed [cbpw_pkg::T_W-1:0] t_reg;
    logic [SHIFT-1:0]       f_reg;
    logic [PIX_W-1:0]       src_reg;
    logic [PIX_W-1:0]       pix_reg;

    logic                   item_accept;
    logic                   inside_in;
    logic [AF_W-1:0]        addr_full;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_addr;
    logic [PIX_W-1:0]       mem_wdata;
    logic [PIX_W-1:0]       mem_rdata;
    logic                   result_load;

    logic [CB-1:0]          a_ch;
    logic [CB-1:0]          b_ch;
    logic [CB-1:0]          cur_ch;
    logic [CB-1:0]          src_ch;
    logic [CB:0]            target_ch;
    logic signed [16:0]     dx;
    logic signed [CB:0]     grad_diff;
    logic signed [CB+1:0]   blend_diff;
    logic [16:0]            cov_clamp;
    logic [24:0]            cov_x255;
    logic                   low_cov;
    logic signed [cbpw_pkg::ACC_W-1:0] grad_sum;
    logic [GQ_W-1:0]        grad_q;
    logic [CB-1:0]          grad_ch;
    logic signed [cbpw_pkg::ACC_W-1:0] blend_sum;
    logic [BR_W-1:0]        blend_r;
    logic [CB-1:0]          blend_ch;

    cbpw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbpw_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (PIX_W)
    ) u_frame_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    cbpw_mul_unit u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (mul_product)
    );

    // Address and frame bounds of the incoming beat
    assign item_accept = item_valid && item_ready;
    assign inside_in   = ({6'd0, item.pixel_x} < FW_C) && ({6'd0, item.pixel_y} < FH_C);
    assign addr_full   = AF_W'(item.pixel_y) * AF_W'(FRAME_WIDTH) + AF_W'(item.pixel_x);

    assign mem_re    = item_accept && inside_in;
    assign mem_addr  = mem_we ? addr_reg : addr_full[ADDR_W-1:0];
    assign mem_wdata = (item_reg.func == cbpw_pkg::FUNC_FILL) ? src_reg : pix_reg;

    // Per-channel operands for the current lane
    assign a_ch      = cfg.color_start[16*ch_reg +: CB];
    assign b_ch      = cfg.color_end[16*ch_reg +: CB];
    assign cur_ch    = mem_rdata[CB*ch_reg +: CB];
    assign src_ch    = src_reg[CB*ch_reg +: CB];
    assign target_ch = (ch_reg == 2'd3) ? CH_ONE : {1'b0, src_ch};

    assign dx         = signed'({10'd0, item_reg.pixel_x}) - 17'(cfg.grad_start_x);
    assign grad_diff  = signed'({1'b0, b_ch}) - signed'({1'b0, a_ch});
    assign blend_diff = signed'({1'b0, target_ch}) - signed'({2'b0, cur_ch});

    // Coverage clamp and low-coverage drop
    assign cov_clamp = (item_reg.coverage > cbpw_pkg::FULL_COV) ? cbpw_pkg::FULL_COV
                                                                 : item_reg.coverage;
    assign cov_x255  = {item_reg.coverage, 8'd0} - {8'd0, item_reg.coverage};
    assign low_cov   = cov_x255 < cbpw_pkg::LOW_COV_LIMIT;

    // Gradient channel: floor and saturate start + t*(end - start)
    assign grad_sum = signed'(cbpw_pkg::ACC_W'({a_ch, 16'd0}))
                    + cbpw_pkg::ACC_W'(mul_product);
    assign grad_q   = grad_sum[cbpw_pkg::ACC_W-1:16];
    assign grad_ch  = grad_sum[cbpw_pkg::ACC_W-1] ? '0
                    : (grad_q > GQ_W'(CH_MAX)) ? CH_MAX : grad_q[CB-1:0];

    // Blend channel: floor of cur + f*(target - cur), clamp to all-ones
    assign blend_sum = signed'(cbpw_pkg::ACC_W'({cur_ch, {SHIFT{1'b0}}}))
                     + cbpw_pkg::ACC_W'(mul_product);
    assign blend_r   = blend_sum[cbpw_pkg::ACC_W-1:SHIFT];
    assign blend_ch  = (blend_r > BR_W'(CH_MAX)) ? CH_MAX : blend_r[CB-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbpw_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = cbpw_pkg::ST_DECODE;
                end
            end
            cbpw_pkg::ST_DECODE:
            begin
                if (item_reg.func == cbpw_pkg::FUNC_READ)
                begin
                    state_next = cbpw_pkg::ST_READ_OUT;
                end
                else if (item_reg.func == cbpw_pkg::FUNC_NONE || !inside_reg)
                begin
                    state_next = cbpw_pkg::ST_IDLE;
                end
                else if (item_reg.func == cbpw_pkg::FUNC_PAINT && low_cov)
                begin
                    state_next = cbpw_pkg::ST_IDLE;
                end
                else if (cfg.shader_mode)
                begin
                    state_next = cbpw_pkg::ST_T_MUL;
                end
                else if (item_reg.func == cbpw_pkg::FUNC_FILL)
                begin
                    state_next = cbpw_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = cbpw_pkg::ST_F_MUL;
                end
            end
            cbpw_pkg::ST_READ_OUT:
            begin
                if (result_load)
                begin
                    state_next = cbpw_pkg::ST_IDLE;
                end
            end
            cbpw_pkg::ST_T_MUL: state_next = cbpw_pkg::ST_T_ACC;
            cbpw_pkg::ST_T_ACC: state_next = cbpw_pkg::ST_G_MUL;
            cbpw_pkg::ST_G_MUL: state_next = cbpw_pkg::ST_G_ACC;
            cbpw_pkg::ST_G_ACC:
            begin
                if (ch_reg != 2'd3)
                begin
                    state_next = cbpw_pkg::ST_G_MUL;
                end
                else if (item_reg.func == cbpw_pkg::FUNC_FILL)
                begin
                    state_next = cbpw_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = cbpw_pkg::ST_F_MUL;
                end
            end
            cbpw_pkg::ST_F_MUL: state_next = cbpw_pkg::ST_F_ACC;
            cbpw_pkg::ST_F_ACC: state_next = cbpw_pkg::ST_B_MUL;
            cbpw_pkg::ST_B_MUL: state_next = cbpw_pkg::ST_B_ACC;
            cbpw_pkg::ST_B_ACC:
            begin
                state_next = (ch_reg == 2'd3) ? cbpw_pkg::ST_WRITE : cbpw_pkg::ST_B_MUL;
            end
            cbpw_pkg::ST_WRITE: state_next = cbpw_pkg::ST_IDLE;
            default:            state_next = cbpw_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory write and multiplier issue
    always_comb
    begin
        item_ready  = (state_reg == cbpw_pkg::ST_IDLE);
        mem_we      = (state_reg == cbpw_pkg::ST_WRITE);
        result_load = (state_reg == cbpw_pkg::ST_READ_OUT)
                   && (!result_valid_reg || result_ready);
        mul_req     = '0;
        unique case (state_reg)
            cbpw_pkg::ST_T_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = cbpw_pkg::MUL_A_W'(dx);
                mul_req.b  = cbpw_pkg::MUL_B_W'(cfg.grad_scale);
            end
            cbpw_pkg::ST_G_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = cbpw_pkg::MUL_A_W'(t_reg);
                mul_req.b  = cbpw_pkg::MUL_B_W'(grad_diff);
            end
            cbpw_pkg::ST_F_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = cbpw_pkg::MUL_A_W'(cov_clamp);
                mul_req.b  = cbpw_pkg::MUL_B_W'(src_reg[3*CB +: CB]);
            end
            cbpw_pkg::ST_B_MUL:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = cbpw_pkg::MUL_A_W'(f_reg);
                mul_req.b  = cbpw_pkg::MUL_B_W'(blend_diff);
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cbpw_pkg::ST_IDLE;
            ch_reg           <= 2'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cbpw_pkg::ST_G_ACC || state_reg == cbpw_pkg::ST_B_ACC)
            begin
                ch_reg <= ch_reg + 2'd1;
            end
            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg   <= item;
            inside_reg <= inside_in;
            addr_reg   <= addr_full[ADDR_W-1:0];
        end
        if (state_reg == cbpw_pkg::ST_DECODE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src_reg[CB*i +: CB] <= cfg.color_start[16*i +: CB];
            end
        end
        if (state_reg == cbpw_pkg::ST_T_ACC)
        begin
            t_reg <= mul_product[cbpw_pkg::T_W-1:0];
        end
        if (state_reg == cbpw_pkg::ST_G_ACC)
        begin
            src_reg[CB*ch_reg +: CB] <= grad_ch;
        end
        if (state_reg == cbpw_pkg::ST_F_ACC)
        begin
            f_reg <= mul_product[SHIFT-1:0];
        end
        if (state_reg == cbpw_pkg::ST_B_ACC)
        begin
            pix_reg[CB*ch_reg +: CB] <= blend_ch;
        end
        if (result_load)
        begin
            result_reg.out_red   <= inside_reg ? to_byte(mem_rdata[0*CB +: CB]) : 8'd0;
            result_reg.out_green <= inside_reg ? to_byte(mem_rdata[1*CB +: CB]) : 8'd0;
            result_reg.out_blue  <= inside_reg ? to_byte(mem_rdata[2*CB +: CB]) : 8'd0;
            result_reg.out_alpha <= inside_reg ? to_byte(mem_rdata[3*CB +: CB]) : 8'd0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks on the sequencer
    `CBPW_ASSERT_NXT(a_busy_after_accept, clk, rst_n, item_valid && item_ready, !item_ready, "beat taken while an item is still in flight")
    `CBPW_ASSERT_IMP(a_result_only_for_read, clk, rst_n, result_load, item_reg.func == cbpw_pkg::FUNC_READ, "result loaded for a non-read item")
    `CBPW_ASSERT_IMP(a_lane_count_idle, clk, rst_n, state_reg == cbpw_pkg::ST_IDLE, ch_reg == 2'd0, "channel counter left mid-sweep")

endmodule

`default_nettype wire

// ===== test/coverage_blend_pixel_writer_top_tb.sv =====
// Self-checking testbench for coverage_blend_pixel_writer_top: paint, fill and read beats
// drive a behavioral compositor in step with the register writes that checks each read.
// Depends on cbpw_pkg and the RTL of the pixel writer only.
`default_nettype none

module coverage_blend_pixel_writer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbpw_pkg::*;

    localparam int FRAME_PIXELS     = 128 * 128;
    localparam int SETTLE_CYCLES    = 40;
    localparam int N_PHASES         = 12;
    localparam int OPS_PER_PHASE    = 162;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 5000;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    wire  [63:0] prdata;
    wire         pready;
    logic        item_valid;
    wire         item_ready;
    item_t       item;
    wire         result_valid;
    logic        result_ready;
    result_t     result;

    coverage_blend_pixel_writer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #6 clk = ~clk;

    // Shadow of the configuration registers
    logic               grad_on;
    logic [63:0]        color_a;
    logic [63:0]        color_b;
    logic signed [15:0] grad_x0;
    logic signed [17:0] grad_k;

    // Shadow frame: channels r, g, b, a in slots 0..3
    logic [3:0][15:0] frame_model [FRAME_PIXELS];
    bit               pix_written [FRAME_PIXELS];
    int               filled_px[$];
    int               hot_px[$];

    result_t     pending_reads[$];
    result_t     oldest_read;
    int unsigned mismatches  = 0;
    int unsigned reads_taken = 0;
    bit          idle_on     = 1'b1;

    // Shader colour of one channel at column x
    function automatic logic [15:0] shade_channel(input int x, input int ch);
        longint lo;
        longint hi;
        longint dx;
        longint v;
        longint q;
        lo = longint'(color_a[16*ch +: 16]);
        hi = longint'(color_b[16*ch +: 16]);
        if (!grad_on)
            return lo[15:0];
        dx = longint'(x) - longint'(grad_x0);
        v  = lo * 65536 + dx * longint'(grad_k) * (hi - lo);
        if (v < 0)
            return 16'h0000;
        q = v >>> 16;
        if (q > 65535)
            return 16'hFFFF;
        return q[15:0];
    endfunction

    function automatic logic [7:0] channel_to_byte(input logic [15:0] c);
        longint p;
        if (c == 16'hFFFF)
            return 8'd255;
        p = (longint'(c) * 255) >>> 16;
        return p[7:0];
    endfunction

    // Apply one accepted beat to the shadow frame; report the read result it causes
    function automatic void composite_pixel(input item_t op, output result_t rd,
                                            output bit has_rd);
        int                   idx;
        logic [3:0][15:0]     src;
        logic [16:0]          cv;
        longint unsigned      f;
        longint unsigned      g;
        longint unsigned      tgt;
        longint unsigned      num;
        longint unsigned      r;
        idx    = {op.pixel_y, op.pixel_x};
        has_rd = 1'b0;
        rd     = '0;
        for (int i = 0; i < 4; i++)
            src[i] = shade_channel(op.pixel_x, i);
        case (op.func)
            FUNC_READ: begin
                has_rd       = 1'b1;
                rd.out_red   = channel_to_byte(frame_model[idx][0]);
                rd.out_green = channel_to_byte(frame_model[idx][1]);
                rd.out_blue  = channel_to_byte(frame_model[idx][2]);
                rd.out_alpha = channel_to_byte(frame_model[idx][3]);
            end
            FUNC_FILL: begin
                frame_model[idx] = src;
                if (!pix_written[idx])
                    filled_px.push_back(idx);
                pix_written[idx] = 1'b1;
            end
            FUNC_PAINT: begin
                // drop coverage below 1/255, clamp above full
                if (longint'(op.coverage) * 255 >= 65536) begin
                    cv = (op.coverage > FULL_COV) ? FULL_COV : op.coverage;
                    f  = longint'(cv) * longint'(src[3]);
                    g  = (64'd1 << 32) - f;
                    for (int i = 0; i < 4; i++) begin
                        tgt = (i == 3) ? 64'd65536 : longint'(src[i]);
                        num = longint'(frame_model[idx][i]) * g + tgt * f;
                        r   = num >> 32;
                        frame_model[idx][i] = (r > 65535) ? 16'hFFFF : r[15:0];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Draw one random beat; paint and read only touch pixels filled earlier
    function automatic item_t pick_op();
        item_t op;
        int    sel;
        int    idx;
        op  = '0;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            op.func     = FUNC_FILL;
            op.coverage = 17'($urandom_range(0, 131071));
            if (hot_px.size() >= 8 && $urandom_range(0, 1) == 0)
                idx = hot_px[$urandom_range(0, hot_px.size() - 1)];
            else begin
                idx = $urandom_range(0, FRAME_PIXELS - 1);
                hot_px.push_back(idx);
                if (hot_px.size() > 8)
                    void'(hot_px.pop_front());
            end
        end
        else if (sel < 95) begin
            op.func = (sel < 60) ? FUNC_PAINT : FUNC_READ;
            if (hot_px.size() != 0 && $urandom_range(0, 1) == 0)
                idx = hot_px[$urandom_range(0, hot_px.size() - 1)];
            else
                idx = filled_px[$urandom_range(0, filled_px.size() - 1)];
            case ($urandom_range(0, 9))
                0:       op.coverage = 17'($urandom_range(0, 300));
                1:       op.coverage = 17'($urandom_range(65536, 131071));
                2:       op.coverage = FULL_COV;
                default: op.coverage = 17'($urandom_range(0, 65536));
            endcase
        end
        else begin
            op.func     = FUNC_NONE;
            op.coverage = 17'($urandom_range(0, 131071));
            idx         = $urandom_range(0, FRAME_PIXELS - 1);
        end
        op.pixel_x = idx[6:0];
        op.pixel_y = idx[13:7];
        return op;
    endfunction

    // Offer one beat and hold it until accepted
    task automatic drive_beat(input item_t op);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= op;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Offer a beat, then record the read result it should produce
    task automatic issue(input item_t op, input bit typed, input result_t want);
        result_t rd;
        bit      has_rd;
        drive_beat(op);
        composite_pixel(op, rd, has_rd);
        if (has_rd)
            pending_reads.push_back(typed ? want : rd);
    endtask

    // Drop valid and wait until the block has gone quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup and access phase; the register takes the value at the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SHADER_MODE:  grad_on = value[0];
            REG_COLOR_START:  color_a = value;
            REG_COLOR_END:    color_b = value;
            REG_GRAD_START_X: grad_x0 = value[15:0];
            REG_GRAD_SCALE:   grad_k  = value[17:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare every accepted result beat with the oldest pending read
    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, result);
                mismatches++;
            end
            else begin
                oldest_read = pending_reads.pop_front();
                check_field("out_red",   oldest_read.out_red,   result.out_red);
                check_field("out_green", oldest_read.out_green, result.out_green);
                check_field("out_blue",  oldest_read.out_blue,  result.out_blue);
                check_field("out_alpha", oldest_read.out_alpha, result.out_alpha);
            end
        end
    end

    // Receiver: random stall after each beat when idle_on, one long hold to back up the block
    initial begin
        int stall;
        result_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        result_ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (result_valid && result_ready) begin
                reads_taken++;
                if (reads_taken == LONG_HOLD_AT)
                    stall = LONG_HOLD_CYCLES;
                else
                    stall = idle_on ? $urandom_range(0, 8) : 0;
                if (stall > 0) begin
                    result_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    result_ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    typedef struct {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [63:0] value;
        item_t       op;
        bit          typed;
        result_t     want;
    } dir_row_t;

    function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [63:0] value);
        dir_row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    function automatic dir_row_t op_row(input logic [1:0] func, input int x, input int y,
                                        input int cov, input bit typed, input result_t want);
        dir_row_t row;
        row             = '{default: '0};
        row.op.func     = func;
        row.op.pixel_x  = 7'(x);
        row.op.pixel_y  = 7'(y);
        row.op.coverage = 17'(cov);
        row.typed       = typed;
        row.want        = want;
        return row;
    endfunction

    // Main stimulus
    initial begin
        dir_row_t dir_rows[$];
        result_t  ones;
        result_t  zeros;
        result_t  dc;
        int       v;
        logic signed [15:0] x0;
        logic signed [17:0] k;

        ones  = '1;
        zeros = '0;
        dc    = '0;
        grad_on = 1'b0;
        color_a = '0;
        color_b = '0;
        grad_x0 = '0;
        grad_k  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        item_valid = 1'b0;
        item       = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: solid black and white, coverage thresholds, gradient saturation
        dir_rows.push_back(cfg_row(REG_SHADER_MODE, 64'd0));
        dir_rows.push_back(cfg_row(REG_COLOR_START, 64'd0));
        dir_rows.push_back(op_row(FUNC_FILL,    0,   0, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    0,   0, 0,        1'b1, zeros));
        dir_rows.push_back(cfg_row(REG_COLOR_START, '1));
        dir_rows.push_back(op_row(FUNC_FILL,    127, 127, 131071, 1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    127, 127, 0,      1'b1, ones));
        dir_rows.push_back(op_row(FUNC_PAINT,   0,   0, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    0,   0, 0,        1'b1, zeros));
        dir_rows.push_back(op_row(FUNC_PAINT,   0,   0, 256,      1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    0,   0, 0,        1'b1, zeros));
        dir_rows.push_back(op_row(FUNC_PAINT,   0,   0, 258,      1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    0,   0, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_PAINT,   0,   0, 131071,   1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    0,   0, 131071,   1'b0, dc));
        dir_rows.push_back(op_row(FUNC_NONE,    5,   5, 65536,    1'b0, dc));
        dir_rows.push_back(op_row(FUNC_FILL,    127, 0, 65536,    1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    127, 0, 0,        1'b1, ones));
        dir_rows.push_back(cfg_row(REG_SHADER_MODE, 64'd1));
        dir_rows.push_back(cfg_row(REG_COLOR_START, 64'd0));
        dir_rows.push_back(cfg_row(REG_COLOR_END, '1));
        dir_rows.push_back(cfg_row(REG_GRAD_START_X, 64'd0));
        dir_rows.push_back(cfg_row(REG_GRAD_SCALE, 64'd512));
        dir_rows.push_back(op_row(FUNC_FILL,    64,  3, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    64,  3, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_PAINT,   64,  3, 65536,    1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    64,  3, 0,        1'b0, dc));
        dir_rows.push_back(cfg_row(REG_GRAD_START_X, 64'h7FFF));
        dir_rows.push_back(cfg_row(REG_GRAD_SCALE, 64'h20000));
        dir_rows.push_back(op_row(FUNC_FILL,    0,   1, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    0,   1, 0,        1'b1, ones));
        dir_rows.push_back(cfg_row(REG_GRAD_START_X, 64'h8000));
        dir_rows.push_back(cfg_row(REG_GRAD_SCALE, 64'h1FFFF));
        dir_rows.push_back(op_row(FUNC_FILL,    127, 2, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    127, 2, 0,        1'b1, ones));
        dir_rows.push_back(cfg_row(REG_GRAD_SCALE, 64'h20000));
        dir_rows.push_back(op_row(FUNC_FILL,    127, 2, 0,        1'b0, dc));
        dir_rows.push_back(op_row(FUNC_READ,    127, 2, 0,        1'b1, zeros));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            else
                issue(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each with a fresh register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            idle_on = (ph % 4 != 1);
            case (ph % 6)
                0: begin
                    x0 = 16'sh8000;
                    k  = 18'sh20000;
                end
                3: begin
                    x0 = 16'sh7FFF;
                    k  = 18'sh1FFFF;
                end
                5: begin
                    x0 = 16'($urandom);
                    k  = 18'($urandom);
                end
                default: begin
                    v  = int'($urandom_range(0, 255)) - 64;
                    x0 = 16'(v);
                    v  = int'($urandom_range(0, 2048)) - 1024;
                    k  = 18'(v);
                end
            endcase
            write_reg(REG_SHADER_MODE, {63'd0, 1'(ph % 3 != 0)});
            write_reg(REG_COLOR_START, (ph == 0) ? '1 : (ph == 4) ? 64'd0 : {$urandom, $urandom});
            write_reg(REG_COLOR_END,   (ph == 4) ? '1 : (ph == 7) ? 64'd0 : {$urandom, $urandom});
            write_reg(REG_GRAD_START_X, {48'd0, x0});
            write_reg(REG_GRAD_SCALE,   {46'd0, k});
            for (int n = 0; n < OPS_PER_PHASE; n++) begin
                // once in phase 2, hold off until every pending read is back
                if (ph == 2 && n == 80) begin
                    item_valid <= 1'b0;
                    while (pending_reads.size() != 0)
                        @(posedge clk);
                end
                issue(pick_op(), 1'b0, dc);
            end
        end

        // Drain and report
        item_valid <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending_reads.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_reads.size() != 0) begin
            $display("%0t: missing results, expected %0d more, actual 0",
                     $time, pending_reads.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== coverage_blend_pixel_writer_top.f =====
+incdir+rtl
rtl/cbpw_pkg.sv
rtl/cbpw_regs.sv
rtl/cbpw_frame_mem.sv
rtl/cbpw_mul_unit.sv
rtl/coverage_blend_pixel_writer_top.sv
test/coverage_blend_pixel_writer_top_tb.sv
